[hw/rtl/fcxy_pkg.sv]
// Package for the frame curvature unit: shared constants, types and the
// controller-to-datapath command/status structs. No dependencies.
`default_nettype none
package fcxy_pkg;
  localparam int unsigned PixW  = 16;
  localparam int unsigned CurvW = 17;
  localparam int unsigned ProdW = 34;
  localparam int unsigned RootSteps = 17;

  localparam logic [1:0] MODE_GEOMEAN = 2'd0;
  localparam logic [1:0] MODE_ROW     = 2'd1;
  localparam logic [1:0] MODE_COLUMN  = 2'd2;

  // command from controller to datapath
  typedef struct packed {
    logic load;       // capture the input word and neighbors, start work
    logic root_step;  // advance the root by one digit
    logic emit;       // move the finished result to the output register
    logic out_pop;    // output word taken downstream
  } fcxy_cmd_t;

  // status back to controller
  typedef struct packed {
    logic out_full;
    logic has_result;
  } fcxy_sts_t;
endpackage
`default_nettype wire

[hw/rtl/fcxy_ram.sv]
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module fcxy_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output      logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

[hw/rtl/fcxy_ctrl.sv]
// Controller state machine for the frame curvature unit.
// Depends on fcxy_pkg.
`default_nettype none
module fcxy_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_fire,
  input  wire logic              geomean,
  input  wire logic              out_fire,
  input  wire fcxy_pkg::fcxy_sts_t sts,
  output      logic              in_ready,
  output      fcxy_pkg::fcxy_cmd_t cmd
);
  import fcxy_pkg::*;
  localparam logic [2:0] S_IDLE = 3'd0, S_READ = 3'd1, S_CALC = 3'd2,
                         S_ROOT = 3'd3, S_EMIT = 3'd4;
  logic [2:0] state_r, state_nxt;
  logic [4:0] step_r, step_nxt;

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    cmd       = '0;
    cmd.out_pop = out_fire;
    in_ready  = (state_r == S_IDLE);
    unique case (state_r)
      S_IDLE: if (in_fire) state_nxt = S_READ;
      S_READ: begin
        // store read data lands this cycle; capture operands
        cmd.load = 1'b1;
        state_nxt = S_CALC;
      end
      S_CALC: begin
        if (!sts.has_result) state_nxt = S_IDLE;
        else if (geomean) begin
          step_nxt = 5'(RootSteps - 1);
          state_nxt = S_ROOT;
        end else state_nxt = S_EMIT;
      end
      S_ROOT: begin
        cmd.root_step = 1'b1;
        step_nxt = step_r - 5'd1;
        if (step_r == 5'd0) state_nxt = S_EMIT;
      end
      S_EMIT: if (!sts.out_full || out_fire) begin
        cmd.emit = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end
endmodule
`default_nettype wire

[hw/rtl/fcxy_dp.sv]
// Datapath for the frame curvature unit: counters, two row stores,
// stencil arithmetic, bit-serial square root and output register.
// Depends on fcxy_pkg and fcxy_ram.
`default_nettype none
module fcxy_dp #(
  parameter int unsigned FrameWidth  = 64,
  parameter int unsigned FrameHeight = 8
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_fire,
  input  wire logic [15:0]           pixel,
  input  wire logic [1:0]            mode,
  input  wire fcxy_pkg::fcxy_cmd_t   cmd,
  output      fcxy_pkg::fcxy_sts_t   sts,
  output      logic                  out_valid,
  output      logic [31:0]           out_word,
  output      logic                  out_last
);
  import fcxy_pkg::*;
  localparam int unsigned CW = $clog2(FrameWidth);
  localparam int unsigned RW = $clog2(FrameHeight + 1);

  logic [CW-1:0] col_r, ccol_r;
  logic [RW-1:0] row_r, crow_r;
  logic [15:0]   pix_r;
  logic [15:0]   prev_c, prev_r1, old_c, left_r;
  logic          last_col;

  assign last_col = (col_r == CW'(FrameWidth - 1));

  // previous row: read at c (center) and c+1 (right); two copies
  logic [CW-1:0] nxt_col;
  assign nxt_col = last_col ? '0 : col_r + CW'(1);

  fcxy_ram #(.Width(16), .Depth(FrameWidth)) u_prev_a (
    .clk, .we(cmd.load), .waddr(ccol_r), .wdata(pix_r),
    .raddr(col_r), .rdata(prev_c));
  fcxy_ram #(.Width(16), .Depth(FrameWidth)) u_prev_b (
    .clk, .we(cmd.load), .waddr(ccol_r), .wdata(pix_r),
    .raddr(nxt_col), .rdata(prev_r1));
  fcxy_ram #(.Width(16), .Depth(FrameWidth)) u_old (
    .clk, .we(cmd.load), .waddr(ccol_r), .wdata(prev_c),
    .raddr(col_r), .rdata(old_c));

  // counters advance at accept; capture item's position
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (in_fire) begin
      col_r <= nxt_col;
      if (last_col) row_r <= (row_r == RW'(FrameHeight)) ? '0 : row_r + RW'(1);
    end
  end
  always_ff @(posedge clk) begin
    if (in_fire) begin
      pix_r  <= pixel;
      ccol_r <= col_r;
      crow_r <= row_r;
    end
  end

  // stencil
  logic signed [18:0] dx, dy;
  logic signed [18:0] lft, rgt, up, dn, ctr;
  logic [CurvW-1:0]   cx_r, cy_r;
  logic               have_r;
  always_comb begin
    ctr = 19'(signed'(prev_c));
    lft = (ccol_r != '0) ? 19'(signed'(left_r)) : '0;
    rgt = (ccol_r != CW'(FrameWidth - 1)) ? 19'(signed'(prev_r1)) : '0;
    up  = (crow_r >= RW'(2)) ? 19'(signed'(old_c)) : '0;
    dn  = (crow_r != RW'(FrameHeight)) ? 19'(signed'(pix_r)) : '0;
    dx  = (ctr <<< 1) - lft - rgt;
    dy  = (ctr <<< 1) - up - dn;
  end
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cx_r   <= dx[18] ? '0 : dx[CurvW-1:0];
      cy_r   <= dy[18] ? '0 : dy[CurvW-1:0];
      left_r <= prev_c; // becomes prev[c-1] for next column
    end
  end
  always_ff @(posedge clk) begin
    if (!rst_n) have_r <= 1'b0;
    else if (cmd.load) have_r <= (crow_r != '0);
  end
  assign sts.has_result = have_r;

  // product (one 17x17 multiply) feeds the first root digit, then one digit a cycle
  logic [ProdW-1:0] prod_r, rem_r;
  logic [CurvW-1:0] root_r;
  logic [ProdW+1:0] trial;
  logic [ProdW-1:0] prod_next;
  logic             first_r;
  assign prod_next = ProdW'(cx_r) * ProdW'(cy_r);
  always_comb trial = {rem_r, prod_r[ProdW-1 -: 2]} - {(ProdW-CurvW)'(0), root_r, 2'b01};
  always_ff @(posedge clk) begin
    if (cmd.load) first_r <= 1'b1;
    else if (cmd.root_step) begin
      first_r <= 1'b0;
      if (first_r) begin
        // first step sees raw product
        prod_r <= prod_next << 2;
        rem_r  <= ProdW'(prod_next[ProdW-1 -: 2]) - ProdW'(prod_next[ProdW-1 -: 2] != 0);
        root_r <= CurvW'(prod_next[ProdW-1 -: 2] != 0);
      end else begin
        prod_r <= prod_r << 2;
        if (!trial[ProdW+1]) begin
          rem_r  <= trial[ProdW-1:0];
          root_r <= {root_r[CurvW-2:0], 1'b1};
        end else begin
          rem_r  <= {rem_r[ProdW-3:0], prod_r[ProdW-1 -: 2]};
          root_r <= {root_r[CurvW-2:0], 1'b0};
        end
      end
    end
  end

  // output register
  logic [CurvW-1:0] val;
  logic [2:0]       orow;
  always_comb begin
    case (mode)
      MODE_ROW:    val = cx_r;
      MODE_COLUMN: val = cy_r;
      default:     val = root_r;
    endcase
    orow = 3'(crow_r - RW'(1));
  end
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid <= 1'b0;
    else if (cmd.emit) out_valid <= 1'b1;
    else if (cmd.out_pop) out_valid <= 1'b0;
  end
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_word <= {6'd0, 6'(ccol_r), orow, val};
      out_last <= (crow_r == RW'(FrameHeight)) && (ccol_r == CW'(FrameWidth - 1));
    end
  end
  assign sts.out_full = out_valid;
endmodule
`default_nettype wire

[hw/rtl/frame_curvature_xy_unit.sv]
// Top level of the frame curvature unit: wires controller and datapath.
// Depends on fcxy_pkg, fcxy_ctrl, fcxy_dp, fcxy_ram.
//
//  channel | direction | payload
//  in_     | slave     | tdata: pixel_value[15:0]
//  out_    | master    | tdata: curvature[16:0], out_row[19:17], out_column[25:20]; tlast frame_last
//  cfg_    | write     | output_mode[1:0]
//
// Each word passes through read and calc states, then emit; in modes 0 and 3 root
// steps for the 17 root digits of the bit-serial square-root unit come first.
// First-row words give no result and skip emit. The read state waits for the
// registered row-store read data. Reset is synchronous, active low; it clears
// counters, mode and handshake state, not the stores. A full output register
// stalls the controller before its emit step; the input side waits meanwhile.
`default_nettype none
module frame_curvature_xy_unit #(
  parameter int unsigned FRAME_WIDTH  = 64,
  parameter int unsigned FRAME_HEIGHT = 8
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output      logic        in_tready,
  input  wire logic [15:0] in_tdata,   // pixel_value[15:0]
  output      logic        out_tvalid,
  input  wire logic        out_tready,
  output      logic [31:0] out_tdata,  // curvature, out_row, out_column, zero fill
  output      logic        out_tlast,  // frame_last
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_wdata   // output_mode
);
  import fcxy_pkg::*;
  logic [1:0] mode_r;
  fcxy_cmd_t  cmd;
  fcxy_sts_t  sts;
  logic in_fire, out_fire;
  assign in_fire  = in_tvalid & in_tready;
  assign out_fire = out_tvalid & out_tready;

  // hold mode; mode 3 acts as geometric mean
  always_ff @(posedge clk) begin
    if (!rst_n) mode_r <= MODE_GEOMEAN;
    else if (cfg_we) mode_r <= cfg_wdata;
  end

  fcxy_ctrl u_ctrl (
    .clk, .rst_n, .in_fire,
    .geomean((mode_r != MODE_ROW) && (mode_r != MODE_COLUMN)),
    .out_fire, .sts, .in_ready(in_tready), .cmd);

  fcxy_dp #(.FrameWidth(FRAME_WIDTH), .FrameHeight(FRAME_HEIGHT)) u_dp (
    .clk, .rst_n, .in_fire, .pixel(in_tdata), .mode(mode_r), .cmd, .sts,
    .out_valid(out_tvalid), .out_word(out_tdata), .out_last(out_tlast));
endmodule
`default_nettype wire

[hw/rtl/fcxy_checker.sv]
// Port-level checker for the frame curvature unit, bound to the top level.
// Depends on frame_curvature_xy_unit ports only.
`default_nettype none
module fcxy_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [31:0] out_tdata,
  input wire logic        out_tlast
);
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output word changed while stalled");
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second word accepted while busy");
  a_zero_fill: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[31:26] == 6'd0)
    else $error("padding bits set");
  a_last_col: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tdata[25:20] == 6'd63)
    else $error("frame end not on last column");
endmodule
bind frame_curvature_xy_unit fcxy_checker u_fcxy_checker (.*);
`default_nettype wire
